FILE: sv/tpcs_pkg.sv
// ----------------------------------------------------------------------------
// tpcs_pkg: shared types and codes for the two-process CPU scheduler
// Holds the widths, the process state codes, the policy codes, the register
// indexes, the state and configuration records and the saturating helpers.
// ----------------------------------------------------------------------------
package tpcs_pkg;

  // Width of the burst down-counters and of the saturating totals
  localparam int BURST_WIDTH = 8;
  localparam int COUNT_WIDTH = 16;

  // Width of the round robin slice, set by the quantum register
  localparam int SLICE_WIDTH = 8;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 8;

  // Stream payload widths in bytes-aligned form
  localparam int IN_DATA_WIDTH  = 8;
  localparam int OUT_DATA_WIDTH = 72;

  typedef logic [BURST_WIDTH-1:0]     burst_t;
  typedef logic [COUNT_WIDTH-1:0]     count_t;
  typedef logic [SLICE_WIDTH-1:0]     slice_t;
  typedef logic [1:0]                 status_t;
  typedef logic [1:0]                 mode_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [CFG_DATA_WIDTH-1:0]  cfg_data_t;

  // Process state codes
  localparam status_t ST_READY = 2'd0;
  localparam status_t ST_RUN   = 2'd1;
  localparam status_t ST_WAIT  = 2'd2;
  localparam status_t ST_DONE  = 2'd3;

  // Scheduling policy codes
  localparam mode_t MODE_FCFS = 2'd0;
  localparam mode_t MODE_SJF  = 2'd1;
  localparam mode_t MODE_PSJF = 2'd2;
  localparam mode_t MODE_RR   = 2'd3;

  // Configuration register indexes
  localparam cfg_index_t CFG_MODE      = 3'd0;
  localparam cfg_index_t CFG_QUANTUM   = 3'd1;
  localparam cfg_index_t CFG_P1_FIRST  = 3'd2;
  localparam cfg_index_t CFG_P1_IO     = 3'd3;
  localparam cfg_index_t CFG_P1_SECOND = 3'd4;
  localparam cfg_index_t CFG_P2_FIRST  = 3'd5;
  localparam cfg_index_t CFG_P2_IO     = 3'd6;
  localparam cfg_index_t CFG_P2_SECOND = 3'd7;

  // Configuration registers as seen by the tick logic
  typedef struct packed {
    mode_t                 mode;
    slice_t                quantum;
    logic [1:0][7:0]       first_burst;
    logic [1:0][7:0]       io_burst;
    logic [1:0][7:0]       second_burst;
  } sched_cfg_t;

  // Scheduler state carried from one tick to the next
  typedef struct packed {
    logic [1:0][1:0]             status;
    logic [1:0][BURST_WIDTH-1:0] cpu_left;
    logic [1:0][BURST_WIDTH-1:0] io_left;
    slice_t                      slice_left;
    logic [1:0][COUNT_WIDTH-1:0] wait_total;
    count_t                      busy_total;
    count_t                      tick_total;
  } sched_state_t;

  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic burst_t burst_dec(burst_t v);
    return (v == '0) ? v : v - burst_t'(1);
  endfunction

  function automatic slice_t slice_dec(slice_t v);
    return (v == '0) ? v : v - slice_t'(1);
  endfunction

endpackage

FILE: sv/tpcs_tick.sv
// ----------------------------------------------------------------------------
// tpcs_tick: next-state logic for one scheduler tick
// Applies restart, burst completion, the policy step, IO completion,
// dispatch and the counter updates to the current state in one pass.
// ----------------------------------------------------------------------------
module tpcs_tick (
  input  tpcs_pkg::sched_cfg_t   cfg,
  input  logic                   restart,
  input  tpcs_pkg::sched_state_t cur,
  output tpcs_pkg::sched_state_t nxt
);

  always_comb begin
    logic pick2;
    nxt   = cur;
    pick2 = 1'b0;

    // Reload from the configuration registers
    if (restart) begin
      for (int k = 0; k < 2; k++) begin
        nxt.status[k]     = tpcs_pkg::ST_READY;
        nxt.cpu_left[k]   = tpcs_pkg::burst_t'(cfg.first_burst[k]);
        nxt.io_left[k]    = tpcs_pkg::burst_t'(cfg.io_burst[k]);
        nxt.wait_total[k] = '0;
      end
      nxt.slice_left = cfg.quantum;
      nxt.busy_total = '0;
      nxt.tick_total = '0;
    end

    // Simulate the tick unless both processes are done
    if (!(nxt.status[0] == tpcs_pkg::ST_DONE && nxt.status[1] == tpcs_pkg::ST_DONE)) begin
      nxt.tick_total = tpcs_pkg::sat_inc(nxt.tick_total);

      // Retire a used-up CPU burst, process 1 first, one per tick
      if (nxt.status[0] == tpcs_pkg::ST_RUN && nxt.cpu_left[0] == '0) begin
        nxt.status[0] = (nxt.io_left[0] == '0) ? tpcs_pkg::ST_DONE : tpcs_pkg::ST_WAIT;
      end else if (nxt.status[1] == tpcs_pkg::ST_RUN && nxt.cpu_left[1] == '0) begin
        nxt.status[1] = (nxt.io_left[1] == '0) ? tpcs_pkg::ST_DONE : tpcs_pkg::ST_WAIT;
      end

      // Policy step: preempt every tick, or on slice expiry
      if (cfg.mode == tpcs_pkg::MODE_PSJF) begin
        for (int k = 0; k < 2; k++) begin
          if (nxt.status[k] == tpcs_pkg::ST_RUN) begin
            nxt.status[k] = tpcs_pkg::ST_READY;
          end
        end
      end else if (cfg.mode == tpcs_pkg::MODE_RR) begin
        if (nxt.status[0] == tpcs_pkg::ST_RUN && nxt.slice_left == '0) begin
          nxt.status[0] = tpcs_pkg::ST_READY;
          if (nxt.status[1] == tpcs_pkg::ST_READY) begin
            nxt.status[1]  = tpcs_pkg::ST_RUN;
            nxt.slice_left = cfg.quantum;
          end
        end
        if (nxt.status[1] == tpcs_pkg::ST_RUN && nxt.slice_left == '0) begin
          nxt.status[1] = tpcs_pkg::ST_READY;
          if (nxt.status[0] == tpcs_pkg::ST_READY) begin
            nxt.status[0]  = tpcs_pkg::ST_RUN;
            nxt.slice_left = cfg.quantum;
          end
        end
      end

      // End IO and load the second burst
      for (int k = 0; k < 2; k++) begin
        if (nxt.status[k] == tpcs_pkg::ST_WAIT && nxt.io_left[k] == '0) begin
          nxt.status[k]   = tpcs_pkg::ST_READY;
          nxt.cpu_left[k] = tpcs_pkg::burst_t'(cfg.second_burst[k]);
        end
      end

      // Dispatch; shortest remaining burst wins in the sjf modes
      if (nxt.status[0] == tpcs_pkg::ST_READY && nxt.status[1] == tpcs_pkg::ST_READY) begin
        pick2 = (cfg.mode == tpcs_pkg::MODE_SJF || cfg.mode == tpcs_pkg::MODE_PSJF) &&
                (nxt.cpu_left[1] < nxt.cpu_left[0]);
        nxt.status[pick2] = tpcs_pkg::ST_RUN;
        nxt.slice_left    = cfg.quantum;
      end else if (nxt.status[0] == tpcs_pkg::ST_READY &&
                   nxt.status[1] != tpcs_pkg::ST_RUN) begin
        nxt.status[0]  = tpcs_pkg::ST_RUN;
        nxt.slice_left = cfg.quantum;
      end else if (nxt.status[1] == tpcs_pkg::ST_READY &&
                   nxt.status[0] != tpcs_pkg::ST_RUN) begin
        nxt.status[1]  = tpcs_pkg::ST_RUN;
        nxt.slice_left = cfg.quantum;
      end

      // Advance the down-counters and the totals
      nxt.slice_left = tpcs_pkg::slice_dec(nxt.slice_left);
      for (int k = 0; k < 2; k++) begin
        case (nxt.status[k])
          tpcs_pkg::ST_RUN: begin
            nxt.cpu_left[k] = tpcs_pkg::burst_dec(nxt.cpu_left[k]);
            nxt.busy_total  = tpcs_pkg::sat_inc(nxt.busy_total);
          end
          tpcs_pkg::ST_WAIT: begin
            nxt.io_left[k] = tpcs_pkg::burst_dec(nxt.io_left[k]);
          end
          tpcs_pkg::ST_READY: begin
            nxt.wait_total[k] = tpcs_pkg::sat_inc(nxt.wait_total[k]);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: sv/two_process_cpu_scheduler.sv
// ----------------------------------------------------------------------------
// two_process_cpu_scheduler: two processes sharing one CPU, one tick per item
// Latency: a result is valid the cycle after its input transfer.
// Throughput: one tick per cycle unless the output stalls; the state register and
// combinational tick logic close the loop; the output register decouples the two sides.
// Reset: both processes done, counters zero, registers at defaults, no result.
// ----------------------------------------------------------------------------
module two_process_cpu_scheduler (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration write port
  input  logic                                     cfg_we,
  input  tpcs_pkg::cfg_index_t                     cfg_index,
  input  tpcs_pkg::cfg_data_t                      cfg_data,
  // input stream
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [0] restart, [7:1] zero
  input  logic [tpcs_pkg::IN_DATA_WIDTH-1:0]       s_axis_tdata,
  // output stream
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // [1:0] p1_state, [3:2] p2_state, [19:4] p1_ready_ticks,
  // [35:20] p2_ready_ticks, [51:36] cpu_busy_ticks, [67:52] trace_length,
  // [68] finished, [71:69] zero
  output logic [tpcs_pkg::OUT_DATA_WIDTH-1:0]      m_axis_tdata
);

  tpcs_pkg::sched_cfg_t   cfg;
  tpcs_pkg::sched_state_t state;
  tpcs_pkg::sched_state_t state_next;
  logic                   in_fire;
  logic                   restart;
  logic                   finished_next;

  assign restart       = s_axis_tdata[0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= tpcs_pkg::MODE_FCFS;
      cfg.quantum      <= tpcs_pkg::slice_t'(1);
      cfg.first_burst  <= {8'd1, 8'd1};
      cfg.io_burst     <= {8'd0, 8'd0};
      cfg.second_burst <= {8'd1, 8'd1};
    end else if (cfg_we) begin
      case (cfg_index)
        tpcs_pkg::CFG_MODE:      cfg.mode            <= cfg_data[1:0];
        tpcs_pkg::CFG_QUANTUM:   cfg.quantum         <= tpcs_pkg::slice_t'(cfg_data);
        tpcs_pkg::CFG_P1_FIRST:  cfg.first_burst[0]  <= cfg_data;
        tpcs_pkg::CFG_P1_IO:     cfg.io_burst[0]     <= cfg_data;
        tpcs_pkg::CFG_P1_SECOND: cfg.second_burst[0] <= cfg_data;
        tpcs_pkg::CFG_P2_FIRST:  cfg.first_burst[1]  <= cfg_data;
        tpcs_pkg::CFG_P2_IO:     cfg.io_burst[1]     <= cfg_data;
        tpcs_pkg::CFG_P2_SECOND: cfg.second_burst[1] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Next-state logic for one tick
  tpcs_tick u_tick (
    .cfg     (cfg),
    .restart (restart),
    .cur     (state),
    .nxt     (state_next)
  );

  assign finished_next = (state_next.status[0] == tpcs_pkg::ST_DONE) &&
                         (state_next.status[1] == tpcs_pkg::ST_DONE);

  // Scheduler state register, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state.status     <= {tpcs_pkg::ST_DONE, tpcs_pkg::ST_DONE};
      state.cpu_left   <= '0;
      state.io_left    <= '0;
      state.slice_left <= '0;
      state.wait_total <= '0;
      state.busy_total <= '0;
      state.tick_total <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register: load a result on transfer in, drop it on transfer out
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {3'b000,
                       finished_next,
                       16'(state_next.tick_total),
                       16'(state_next.busy_total),
                       16'(state_next.wait_total[1]),
                       16'(state_next.wait_total[0]),
                       state_next.status[1],
                       state_next.status[0]};
    end
  end

  // The CPU is never held by both processes
  a_single_runner: assert property (@(posedge clk) disable iff (rst)
    !(state.status[0] == tpcs_pkg::ST_RUN && state.status[1] == tpcs_pkg::ST_RUN))
    else $error("both processes running");

  // Busy ticks never exceed simulated ticks
  a_busy_le_ticks: assert property (@(posedge clk) disable iff (rst)
    state.busy_total <= state.tick_total)
    else $error("busy count above tick count");

  // A restart tick always reports a trace length of one
  a_restart_trace: assert property (@(posedge clk) disable iff (rst)
    in_fire && restart |=> m_axis_tvalid && m_axis_tdata[67:52] == 16'd1)
    else $error("restart tick trace length wrong");

  // Once both are done, a tick without restart leaves the state alone
  a_idle_frozen: assert property (@(posedge clk) disable iff (rst)
    in_fire && !restart && state.status[0] == tpcs_pkg::ST_DONE &&
    state.status[1] == tpcs_pkg::ST_DONE |=> $stable(state))
    else $error("finished state changed");

endmodule
